[src/evq_pkg.sv]
// evq_pkg: request, mark and status codes, controller states and the
// command/status structs shared by the event queue scheduler modules.
// No dependencies.
package evq_pkg;

  localparam int REQ_W  = 2;
  localparam int ID_W   = 4;
  localparam int STS_W  = 2;
  localparam int MARK_W = 2;
  localparam int CNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_TRIGGER  = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_FINISH   = 2'd3
  } req_t;

  typedef enum logic [MARK_W-1:0] {
    MK_IDLE = 2'd0,
    MK_PEND = 2'd1,
    MK_EXEC = 2'd2,
    MK_EXRT = 2'd3
  } mark_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_BUSY    = 2'd2,
    STS_IGNORED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_LINK,
    FSM_UNLINK,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic    load;
    logic    push_a;
    logic    push_b;
    logic    unlink;
    logic    run_set;
    logic    run_clr;
    logic    mark_we;
    mark_t   mark_wd;
    logic    res_set;
    status_t res_status;
    logic    res_valid;
    logic    res_requeued;
    mark_t   res_ast;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    req_t  req;
    logic  id_ok;
    mark_t mark_e;
    logic  run_valid;
    logic  head_valid;
    logic  out_busy;
  } sts_t;

endpackage

[src/evq_req_if.sv]
// evq_req_if: request channel of the event queue scheduler.
// Depends on evq_pkg.
interface evq_req_if;
  import evq_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [ID_W-1:0]  event_id;

  modport source (output valid, output req_type, output event_id, input ready);
  modport sink (input valid, input req_type, input event_id, output ready);
endinterface

[src/evq_res_if.sv]
// evq_res_if: result channel of the event queue scheduler.
// Depends on evq_pkg.
interface evq_res_if;
  import evq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic              out_valid;
  logic [ID_W-1:0]   out_event;
  logic              requeued;
  logic [MARK_W-1:0] addressed_state;
  logic [CNT_W-1:0]  queue_count;

  modport source (
    output valid, output status, output out_valid, output out_event,
    output requeued, output addressed_state, output queue_count, input ready
  );
  modport sink (
    input valid, input status, input out_valid, input out_event,
    input requeued, input addressed_state, input queue_count, output ready
  );
endinterface

[src/evq_ctrl.sv]
// evq_ctrl: sequencing state machine of the event queue scheduler.
// Depends on evq_pkg; drives evq_dp through cmd_t, watches sts_t.
module evq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  evq_pkg::sts_t sts,
  output evq_pkg::cmd_t cmd
);
  import evq_pkg::*;

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (in_valid) state_next = FSM_EXEC;
      end
      FSM_EXEC: begin
        state_next = FSM_DONE;
        case (sts.req)
          REQ_TRIGGER: begin
            if (sts.id_ok && sts.mark_e == MK_IDLE) state_next = FSM_LINK;
          end
          REQ_CANCEL: begin
            if (sts.id_ok && sts.mark_e == MK_PEND) state_next = FSM_UNLINK;
          end
          REQ_DISPATCH: begin
            if (!sts.run_valid && sts.head_valid) state_next = FSM_UNLINK;
          end
          REQ_FINISH: begin
            if (sts.run_valid && sts.mark_e == MK_EXRT) state_next = FSM_LINK;
          end
          default: state_next = FSM_DONE;
        endcase
      end
      FSM_LINK:   state_next = FSM_DONE;
      FSM_UNLINK: state_next = FSM_DONE;
      FSM_DONE: begin
        if (!sts.out_busy) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  assign in_ready = (state == FSM_IDLE) && !rst;

  always_comb begin
    cmd = '0;
    case (state)
      FSM_IDLE: begin
        cmd.load = in_valid;
      end
      FSM_EXEC: begin
        cmd.res_set    = 1'b1;
        cmd.res_status = STS_OK;
        cmd.res_ast    = MK_IDLE;
        case (sts.req)
          REQ_TRIGGER: begin
            if (!sts.id_ok) begin
              cmd.res_status = STS_IGNORED;
            end else begin
              case (sts.mark_e)
                MK_IDLE: begin
                  cmd.push_a  = 1'b1;
                  cmd.mark_we = 1'b1;
                  cmd.mark_wd = MK_PEND;
                  cmd.res_ast = MK_PEND;
                end
                MK_EXEC: begin
                  cmd.mark_we = 1'b1;
                  cmd.mark_wd = MK_EXRT;
                  cmd.res_ast = MK_EXRT;
                end
                default: cmd.res_ast = sts.mark_e;
              endcase
            end
          end
          REQ_CANCEL: begin
            if (!sts.id_ok) begin
              cmd.res_status = STS_IGNORED;
            end else if (sts.mark_e != MK_PEND) begin
              cmd.res_status = STS_IGNORED;
              cmd.res_ast    = sts.mark_e;
            end
          end
          REQ_DISPATCH: begin
            if (sts.run_valid) begin
              cmd.res_status = STS_BUSY;
              cmd.res_ast    = sts.mark_e;
            end else if (!sts.head_valid) begin
              cmd.res_status = STS_EMPTY;
            end else begin
              cmd.res_valid = 1'b1;
              cmd.res_ast   = MK_EXEC;
            end
          end
          REQ_FINISH: begin
            if (!sts.run_valid) begin
              cmd.res_status = STS_BUSY;
            end else if (sts.mark_e == MK_EXRT) begin
              cmd.push_a       = 1'b1;
              cmd.mark_we      = 1'b1;
              cmd.mark_wd      = MK_PEND;
              cmd.res_requeued = 1'b1;
              cmd.res_ast      = MK_PEND;
            end else begin
              cmd.mark_we = 1'b1;
              cmd.mark_wd = MK_IDLE;
              cmd.run_clr = 1'b1;
            end
          end
          default: cmd.res_status = STS_OK;
        endcase
      end
      FSM_LINK: begin
        cmd.push_b  = 1'b1;
        cmd.run_clr = (sts.req == REQ_FINISH);
      end
      FSM_UNLINK: begin
        cmd.unlink  = 1'b1;
        cmd.mark_we = 1'b1;
        if (sts.req == REQ_DISPATCH) begin
          cmd.mark_wd = MK_EXEC;
          cmd.run_set = 1'b1;
        end else begin
          cmd.mark_wd = MK_IDLE;
        end
      end
      FSM_DONE: begin
        cmd.out_load = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[src/evq_dp.sv]
// evq_dp: datapath of the event queue scheduler: event marks, link memories,
// head/tail/running pointers, pending count and the result register.
// Depends on evq_pkg; commanded by evq_ctrl.
module evq_dp #(
  parameter int EVENT_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  evq_pkg::cmd_t              cmd,
  output evq_pkg::sts_t              sts,
  input  logic [evq_pkg::REQ_W-1:0]  in_req_type,
  input  logic [evq_pkg::ID_W-1:0]   in_event_id,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [evq_pkg::STS_W-1:0]  res_status,
  output logic                       res_out_valid,
  output logic [evq_pkg::ID_W-1:0]   res_out_event,
  output logic                       res_requeued,
  output logic [evq_pkg::MARK_W-1:0] res_addressed_state,
  output logic [evq_pkg::CNT_W-1:0]  res_queue_count
);
  import evq_pkg::*;

  localparam int IW = $clog2(EVENT_COUNT);
  localparam int LW = $clog2(EVENT_COUNT + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(EVENT_COUNT);

  req_t            req_q;
  logic [ID_W-1:0] id_q;
  logic [LW-1:0]   head;
  logic [LW-1:0]   tail;
  logic [LW-1:0]   running;
  logic [LW-1:0]   total;
  mark_t           mark_q [EVENT_COUNT];
  logic [LW-1:0]   next_mem [EVENT_COUNT];
  logic [LW-1:0]   prev_mem [EVENT_COUNT];
  logic [LW-1:0]   rd_next;
  logic [LW-1:0]   rd_prev;

  status_t         scr_status;
  logic            scr_valid;
  logic [ID_W-1:0] scr_event;
  logic            scr_requeued;
  mark_t           scr_ast;

  logic [LW-1:0]   e_link;
  logic [IW-1:0]   e_idx;
  logic            head_valid;
  logic            tail_valid;
  logic            run_valid;
  logic [LW-1:0]   n_link;
  logic [LW-1:0]   p_link;

  logic            nx_we;
  logic [IW-1:0]   nx_wa;
  logic [LW-1:0]   nx_wd;
  logic            pv_we;
  logic [IW-1:0]   pv_wa;
  logic [LW-1:0]   pv_wd;

  assign head_valid = (head != NULL_LINK);
  assign tail_valid = (tail != NULL_LINK);
  assign run_valid  = (running != NULL_LINK);

  // event addressed by the current request
  always_comb begin
    case (req_q)
      REQ_TRIGGER, REQ_CANCEL: e_link = LW'(id_q);
      REQ_DISPATCH:            e_link = run_valid ? running : head;
      REQ_FINISH:              e_link = running;
      default:                 e_link = running;
    endcase
  end

  assign e_idx = e_link[IW-1:0];

  // the popped head has no predecessor, so its successor gets a null back link
  assign n_link = rd_next;
  assign p_link = (req_q == REQ_DISPATCH) ? NULL_LINK : rd_prev;

  assign sts.req        = req_q;
  assign sts.id_ok      = (int'(id_q) < EVENT_COUNT);
  assign sts.mark_e     = mark_q[e_idx];
  assign sts.run_valid  = run_valid;
  assign sts.head_valid = head_valid;
  assign sts.out_busy   = res_valid && !res_ready;

  always_comb begin
    nx_we = 1'b0;
    nx_wa = e_idx;
    nx_wd = NULL_LINK;
    pv_we = 1'b0;
    pv_wa = e_idx;
    pv_wd = tail;
    if (cmd.push_a) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (cmd.push_b) begin
      nx_we = tail_valid;
      nx_wa = tail[IW-1:0];
      nx_wd = e_link;
    end else if (cmd.unlink) begin
      nx_we = (p_link != NULL_LINK);
      nx_wa = p_link[IW-1:0];
      nx_wd = n_link;
      pv_we = (n_link != NULL_LINK);
      pv_wa = n_link[IW-1:0];
      pv_wd = p_link;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    rd_next <= next_mem[e_idx];
    rd_prev <= prev_mem[e_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NULL_LINK;
      tail      <= NULL_LINK;
      running   <= NULL_LINK;
      total     <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < EVENT_COUNT; i++) begin
        mark_q[i] <= MK_IDLE;
      end
    end else begin
      if (cmd.push_b) begin
        if (!tail_valid) head <= e_link;
        tail <= e_link;
      end else if (cmd.unlink) begin
        if (p_link == NULL_LINK) head <= n_link;
        if (n_link == NULL_LINK) tail <= p_link;
      end
      if (cmd.run_set) begin
        running <= e_link;
      end else if (cmd.run_clr) begin
        running <= NULL_LINK;
      end
      if (cmd.push_a) begin
        total <= total + LW'(1);
      end else if (cmd.unlink) begin
        total <= total - LW'(1);
      end
      if (cmd.mark_we) mark_q[e_idx] <= cmd.mark_wd;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_t'(in_req_type);
      id_q  <= in_event_id;
    end
    if (cmd.res_set) begin
      scr_status   <= cmd.res_status;
      scr_valid    <= cmd.res_valid;
      scr_event    <= cmd.res_valid ? ID_W'(e_link) : '0;
      scr_requeued <= cmd.res_requeued;
      scr_ast      <= cmd.res_ast;
    end
    if (cmd.out_load) begin
      res_status          <= scr_status;
      res_out_valid       <= scr_valid;
      res_out_event       <= scr_event;
      res_requeued        <= scr_requeued;
      res_addressed_state <= scr_ast;
      res_queue_count     <= CNT_W'(total);
    end
  end

endmodule

[src/event_queue_scheduler.sv]
// event_queue_scheduler: top level, FIFO event scheduler with retrigger.
// Depends on evq_pkg, evq_req_if, evq_res_if, evq_ctrl and evq_dp.
//
// Usage: requests enter on the req channel (trigger, cancel, dispatch next,
// finish) with an event id; each request gives exactly one result on the res
// channel with a status, the dispatched event, the requeue flag, the mark of
// the affected event and the pending count after the request.
// A request is taken only while the scheduler is idle. Requests that only
// change a mark pass through the execute and done states to a result in the
// output register; a trigger that enqueues, a finish that requeues, a cancel
// that unlinks and a dispatch that pops the head also pass through a link or
// unlink state for the head/tail or neighbor update after the registered link
// read. A new request is taken only after the last one leaves the done state.
// The result register separates the channels: a new request is taken while a
// result waits; if the receiver stalls, the next request holds in its last
// step until the register frees.
// Synchronous reset returns all events to idle with an empty queue and
// nothing executing; no clearing pass is needed.
module event_queue_scheduler #(
  parameter int EVENT_COUNT = 16
) (
  input logic clk,
  input logic rst,
  evq_req_if.sink   req,
  evq_res_if.source res
);
  import evq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  evq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  evq_dp #(
    .EVENT_COUNT (EVENT_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (req.req_type),
    .in_event_id         (req.event_id),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_status          (res.status),
    .res_out_valid       (res.out_valid),
    .res_out_event       (res.out_event),
    .res_requeued        (res.requeued),
    .res_addressed_state (res.addressed_state),
    .res_queue_count     (res.queue_count)
  );

endmodule

[tb/evq_result_checker.sv]
// evq_result_checker: watches the request and result channels of the event queue
// scheduler, predicts each result from its own copy of the queue state and compares.
// Depends on evq_pkg, evq_req_if and evq_res_if.
module evq_result_checker #(
  parameter int EVENT_COUNT = 16
) (
  input  logic clk,
  input  logic rst,
  evq_req_if   req,
  evq_res_if   res,
  output int   errors,
  output int   in_flight,
  output int   requests,
  output int   dispatches,
  output int   requeues,
  output int   deepest
);
  import evq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CNT_W-1:0] NIL = CNT_W'(EVENT_COUNT);
  localparam int SLOTS = 2 ** CNT_W;

  typedef struct packed {
    status_t           status;
    logic              out_valid;
    logic [ID_W-1:0]   out_event;
    logic              requeued;
    mark_t             ast;
    logic [CNT_W-1:0]  count;
  } result_t;

  mark_t            mark    [SLOTS];
  logic [CNT_W-1:0] fwd_link[SLOTS];
  logic [CNT_W-1:0] bwd_link[SLOTS];
  logic [CNT_W-1:0] head, tail, running, total;

  result_t expected_results[$];

  function automatic void clear_queue();
    for (int i = 0; i < EVENT_COUNT; i++) begin
      mark[i] = MK_IDLE;
      fwd_link[i] = NIL;
      bwd_link[i] = NIL;
    end
    head = NIL;
    tail = NIL;
    running = NIL;
    total = '0;
  endfunction

  function automatic void append_event(logic [CNT_W-1:0] e);
    fwd_link[e] = NIL;
    bwd_link[e] = tail;
    if (tail != NIL) fwd_link[tail] = e;
    else head = e;
    tail = e;
    mark[e] = MK_PEND;
    total = total + 1'b1;
  endfunction

  function automatic void detach_event(logic [CNT_W-1:0] e);
    logic [CNT_W-1:0] p, n;
    p = bwd_link[e];
    n = fwd_link[e];
    if (p != NIL) fwd_link[p] = n;
    else head = n;
    if (n != NIL) bwd_link[n] = p;
    else tail = p;
    fwd_link[e] = NIL;
    bwd_link[e] = NIL;
    if (total != 0) total = total - 1'b1;
  endfunction

  function automatic result_t schedule_request(req_t r, logic [ID_W-1:0] id);
    result_t o;
    logic [CNT_W-1:0] e;
    o = '0;
    o.status = STS_OK;
    o.ast = MK_IDLE;
    e = CNT_W'(id);
    case (r)
      REQ_TRIGGER, REQ_CANCEL: begin
        if (int'(id) >= EVENT_COUNT) begin
          o.status = STS_IGNORED;
        end else if (r == REQ_TRIGGER) begin
          if (mark[e] == MK_IDLE) append_event(e);
          else if (mark[e] == MK_EXEC) mark[e] = MK_EXRT;
          o.ast = mark[e];
        end else begin
          if (mark[e] == MK_PEND) begin
            detach_event(e);
            mark[e] = MK_IDLE;
          end else begin
            o.status = STS_IGNORED;
          end
          o.ast = mark[e];
        end
      end
      REQ_DISPATCH: begin
        if (running != NIL) begin
          o.status = STS_BUSY;
          o.ast = mark[running];
        end else if (head == NIL) begin
          o.status = STS_EMPTY;
        end else begin
          e = head;
          detach_event(e);
          mark[e] = MK_EXEC;
          running = e;
          o.out_valid = 1'b1;
          o.out_event = e[ID_W-1:0];
          o.ast = MK_EXEC;
        end
      end
      default: begin
        if (running == NIL) begin
          o.status = STS_BUSY;
        end else begin
          e = running;
          running = NIL;
          if (mark[e] == MK_EXRT) begin
            append_event(e);
            o.requeued = 1'b1;
          end else begin
            mark[e] = MK_IDLE;
          end
          o.ast = mark[e];
        end
      end
    endcase
    o.count = total;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    result_t got, want;
    if (rst) begin
      clear_queue();
      expected_results.delete();
      in_flight <= 0;
      errors = 0;
      requests = 0;
      dispatches = 0;
      requeues = 0;
      deepest = 0;
    end else begin
      if (res.valid && res.ready) begin
        got.status = status_t'(res.status);
        got.out_valid = res.out_valid;
        got.out_event = res.out_event;
        got.requeued = res.requeued;
        got.ast = mark_t'(res.addressed_state);
        got.count = res.queue_count;
        if (expected_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with nothing outstanding: sts=%0d ov=%0d ev=%0d",
                     $time, got.status, got.out_valid, got.out_event);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.out_valid !== want.out_valid ||
              got.out_event !== want.out_event || got.requeued !== want.requeued ||
              got.ast !== want.ast || got.count !== want.count) begin
            if (errors < 10)
              $display({"%0t: mismatch exp sts=%0d ov=%0d ev=%0d rq=%0d st=%0d cnt=%0d",
                        " | got sts=%0d ov=%0d ev=%0d rq=%0d st=%0d cnt=%0d"},
                       $time, want.status, want.out_valid, want.out_event,
                       want.requeued, want.ast, want.count, got.status,
                       got.out_valid, got.out_event, got.requeued, got.ast, got.count);
            errors = errors + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        want = schedule_request(req_t'(req.req_type), req.event_id);
        expected_results.push_back(want);
        requests = requests + 1;
        if (want.out_valid) dispatches = dispatches + 1;
        if (want.requeued) requeues = requeues + 1;
        if (int'(want.count) > deepest) deepest = int'(want.count);
      end
      in_flight <= expected_results.size();
    end
  end
endmodule

[tb/tb_event_queue_scheduler.sv]
// tb_event_queue_scheduler: drives directed and random scheduler requests with random
// idling on both channels and reports the verdict from evq_result_checker.
// Depends on evq_pkg, evq_req_if, evq_res_if, event_queue_scheduler and evq_result_checker.
module tb_event_queue_scheduler;
  import evq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1700;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_MIXED, MIX_CHURN} mix_t;

  logic clk;
  logic rst;
  int   errors, in_flight, requests, dispatches, requeues, deepest;
  int   gap_pct = 0;
  int   stall_pct = 0;
  bit   calm = 1'b0;
  logic [ID_W-1:0] last_out = '0;

  evq_req_if req_ch();
  evq_res_if res_ch();

  event_queue_scheduler #(.EVENT_COUNT(16)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  evq_result_checker #(.EVENT_COUNT(16)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .errors     (errors),
    .in_flight  (in_flight),
    .requests   (requests),
    .dispatches (dispatches),
    .requeues   (requeues),
    .deepest    (deepest)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_event_queue_scheduler: done, errors");
    $finish;
  end

  // last event handed out, used to aim requests at the executing event
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready && res_ch.out_valid) last_out <= res_ch.out_event;
  end

  initial begin
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(req_t r, logic [ID_W-1:0] id);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r;
    req_ch.event_id <= id;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  function automatic req_t pick_request(mix_t mix);
    int roll, t, c, d;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin t = 70; c = 5;  d = 15; end
      MIX_DRAIN: begin t = 10; c = 15; d = 40; end
      MIX_CHURN: begin t = 30; c = 30; d = 20; end
      default:   begin t = 35; c = 15; d = 25; end
    endcase
    if (roll < t) return REQ_TRIGGER;
    if (roll < t + c) return REQ_CANCEL;
    if (roll < t + c + d) return REQ_DISPATCH;
    return REQ_FINISH;
  endfunction

  function automatic logic [ID_W-1:0] pick_event(mix_t mix);
    if ((mix == MIX_CHURN || mix == MIX_MIXED) && $urandom_range(0, 2) == 0) return last_out;
    return ID_W'($urandom_range(0, 15));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  initial begin
    int   remaining, len;
    mix_t mix;
    req_t r;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_TRIGGER;
    req_ch.event_id <= '0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty queue, nothing executing, idle cancel
    send(REQ_DISPATCH, 4'd0);
    send(REQ_FINISH, 4'd9);
    send(REQ_CANCEL, 4'd3);
    // extremes, pending retrigger, cancel of a pending event
    send(REQ_TRIGGER, 4'd0);
    send(REQ_TRIGGER, 4'd15);
    send(REQ_TRIGGER, 4'd0);
    send(REQ_CANCEL, 4'd15);
    send(REQ_TRIGGER, 4'd5);
    send(REQ_TRIGGER, 4'd15);
    // dispatch, busy dispatch, retrigger while executing, cancel of executing event
    send(REQ_DISPATCH, 4'd0);
    send(REQ_DISPATCH, 4'd0);
    send(REQ_TRIGGER, 4'd0);
    send(REQ_TRIGGER, 4'd0);
    send(REQ_CANCEL, 4'd0);
    send(REQ_FINISH, 4'd0);
    send(REQ_DISPATCH, 4'd0);
    send(REQ_FINISH, 4'd0);
    // unlink head, middle and tail
    send(REQ_CANCEL, 4'd15);
    send(REQ_TRIGGER, 4'd10);
    send(REQ_TRIGGER, 4'd6);
    send(REQ_CANCEL, 4'd10);
    send(REQ_CANCEL, 4'd6);
    send(REQ_CANCEL, 4'd0);
    send(REQ_TRIGGER, 4'd9);
    send(REQ_DISPATCH, 4'd0);
    settle();

    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      len = $urandom_range(40, 150);
      if (len > remaining) len = remaining;
      mix = mix_t'($urandom_range(0, 3));
      if (remaining <= 200) begin
        calm = 1'b1;
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      repeat (len) begin
        r = pick_request(mix);
        send(r, pick_event(mix));
      end
      remaining = remaining - len;
      if (!calm && $urandom_range(0, 3) == 0) settle();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("%0d requests checked: %0d dispatches, %0d requeues after retrigger",
             requests, dispatches, requeues);
    $display("deepest queue reached %0d pending events", deepest);
    if (errors == 0 && in_flight == 0) begin
      $display("tb_event_queue_scheduler: done, clean");
    end else begin
      $display("tb_event_queue_scheduler: done, errors");
    end
    $finish;
  end
endmodule

[sim.f]
src/evq_pkg.sv
src/evq_req_if.sv
src/evq_res_if.sv
src/evq_ctrl.sv
src/evq_dp.sv
src/event_queue_scheduler.sv
tb/evq_result_checker.sv
tb/tb_event_queue_scheduler.sv
